// ===== rtl/clipped_line_rasterizer_core_macros.svh =====
// Assertion macros shared by the rasteriser RTL.
// CLR_ASSERT is disabled while rst_n is low; CLR_ASSERT_ALWAYS is checked during reset too.
`ifndef CLIPPED_LINE_RASTERIZER_CORE_MACROS_SVH
`define CLIPPED_LINE_RASTERIZER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clr assertion failed");

`define CLR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("clr assertion failed");

`else

`define CLR_ASSERT(lbl, prop)

`define CLR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/clr_pkg.sv =====
`default_nettype none
package clr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int COLOR_BITS  = 32;
  localparam int DIM_BITS    = 15;
  localparam int SPAN_X_BITS = COORD_BITS + 1;
  localparam int NSPAN_BITS  = COORD_BITS + 2;
  localparam int ERR_BITS    = COORD_BITS + 3;
  // window compare width: both operands fit signed
  localparam int VIS_BITS    = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(1920);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(1080);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    kind_t                 kind;
    coord_t                x_start;
    coord_t                y_start;
    coord_t                x_end;
    coord_t                y_end;
    logic [COLOR_BITS-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  visible;
    logic                  last;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                         is_start;
    coord_t                       cur_x;
    coord_t                       cur_y;
    coord_t                       goal_x;
    coord_t                       goal_y;
    logic [SPAN_X_BITS-1:0]       span_x;
    logic signed [NSPAN_BITS-1:0] neg_span_y;
    logic                         dir_x_neg;
    logic                         dir_y_neg;
    logic [COLOR_BITS-1:0]        color;
  } cmd_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } win_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/clr_fifo.sv =====
`default_nettype none
`include "clipped_line_rasterizer_core_macros.svh"
module clr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `CLR_ASSERT(a_count_in_range, count_r <= CNT_W'(DEPTH))
  `CLR_ASSERT(a_last_pop_empties, (do_pop && !do_push && count_r == CNT_W'(1)) |=> empty)

endmodule
`default_nettype wire

// ===== rtl/clr_front.sv =====
`default_nettype none
module clr_front
  import clr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  output logic          in_full,
  output logic          q_push,
  output cmd_t          q_data,
  input  wire logic     q_full
);

  logic       stage_v_r, stage_v_nxt;
  cmd_t       stage_r;
  cmd_t       cmd;
  logic       accept;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        mag_x, mag_y;

  // stage holds one classified request until the queue takes it
  assign in_full     = stage_v_r && q_full;
  assign accept      = in_push && !in_full;
  assign q_push      = stage_v_r && !q_full;
  assign q_data      = stage_r;
  assign stage_v_nxt = accept || (stage_v_r && q_full);

  always_comb begin
    dx    = {in_data.x_end[COORD_BITS-1], in_data.x_end}
          - {in_data.x_start[COORD_BITS-1], in_data.x_start};
    dy    = {in_data.y_end[COORD_BITS-1], in_data.y_end}
          - {in_data.y_start[COORD_BITS-1], in_data.y_start};
    mag_x = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    mag_y = dy[COORD_BITS] ? (~dy + 1'b1) : dy;

    cmd            = '0;
    cmd.is_start   = (in_data.kind == KIND_START);
    cmd.cur_x      = in_data.x_start;
    cmd.cur_y      = in_data.y_start;
    cmd.goal_x     = in_data.x_end;
    cmd.goal_y     = in_data.y_end;
    cmd.span_x     = mag_x;
    cmd.neg_span_y = NSPAN_BITS'(0) - {1'b0, mag_y};
    cmd.dir_x_neg  = dx[COORD_BITS] || (dx == '0);
    cmd.dir_y_neg  = dy[COORD_BITS] || (dy == '0);
    cmd.color      = in_data.line_color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/clr_back.sv =====
`default_nettype none
`include "clipped_line_rasterizer_core_macros.svh"
module clr_back
  import clr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_empty,
  input  wire cmd_t     cmd_data,
  output logic          cmd_pop,
  input  wire win_cfg_t win,
  output logic          res_push,
  output out_item_t     res_data,
  input  wire logic     res_full
);

  logic                         active_r, active_nxt;
  coord_t                       cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic                         dir_x_neg_r, dir_y_neg_r;
  logic [SPAN_X_BITS-1:0]       span_x_r;
  logic signed [NSPAN_BITS-1:0] neg_span_y_r;
  logic signed [ERR_BITS-1:0]   err_r, err_nxt, err_init;
  logic [COLOR_BITS-1:0]        color_r;

  logic signed [ERR_BITS:0]     e2, nsy_ext, span_ext;
  logic signed [VIS_BITS-1:0]   x_ext, y_ext, w_ext, h_ext;
  logic                         at_x, at_y, step_x, step_y, last;
  coord_t                       cur_x_nxt, cur_y_nxt;

  assign cmd_pop  = !cmd_empty && (cmd_data.is_start || !active_r || !res_full);
  assign res_push = cmd_pop && !cmd_data.is_start && active_r;

  always_comb begin
    at_x     = (cur_x_r == goal_x_r);
    at_y     = (cur_y_r == goal_y_r);
    e2       = {err_r, 1'b0};
    nsy_ext  = {{2{neg_span_y_r[NSPAN_BITS-1]}}, neg_span_y_r};
    span_ext = {3'b000, span_x_r};
    step_x   = (e2 >= nsy_ext);
    step_y   = (e2 <= span_ext);
    // endpoint reached, or a step along an axis already at its goal
    last     = (at_x && at_y) || (step_x && at_x) || (step_y && at_y);

    err_nxt  = err_r
             + (step_x ? {neg_span_y_r[NSPAN_BITS-1], neg_span_y_r} : ERR_BITS'(0))
             + (step_y ? {2'b00, span_x_r} : ERR_BITS'(0));
    cur_x_nxt = step_x ? cur_x_r + (dir_x_neg_r ? {COORD_BITS{1'b1}} : COORD_BITS'(1))
                       : cur_x_r;
    cur_y_nxt = step_y ? cur_y_r + (dir_y_neg_r ? {COORD_BITS{1'b1}} : COORD_BITS'(1))
                       : cur_y_r;
    err_init  = {2'b00, cmd_data.span_x}
              + {cmd_data.neg_span_y[NSPAN_BITS-1], cmd_data.neg_span_y};

    x_ext = {{(VIS_BITS-COORD_BITS){cur_x_r[COORD_BITS-1]}}, cur_x_r};
    y_ext = {{(VIS_BITS-COORD_BITS){cur_y_r[COORD_BITS-1]}}, cur_y_r};
    w_ext = {{(VIS_BITS-DIM_BITS){1'b0}}, win.width};
    h_ext = {{(VIS_BITS-DIM_BITS){1'b0}}, win.height};

    res_data.pixel_x     = cur_x_r;
    res_data.pixel_y     = cur_y_r;
    res_data.pixel_color = color_r;
    res_data.visible     = (x_ext > VIS_BITS'(0)) && (x_ext < w_ext)
                        && (y_ext > VIS_BITS'(0)) && (y_ext < h_ext);
    res_data.last        = last;

    active_nxt = active_r;
    if (cmd_pop) begin
      if (cmd_data.is_start) begin
        active_nxt = 1'b1;
      end else if (active_r && last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_data.is_start) begin
      cur_x_r      <= cmd_data.cur_x;
      cur_y_r      <= cmd_data.cur_y;
      goal_x_r     <= cmd_data.goal_x;
      goal_y_r     <= cmd_data.goal_y;
      dir_x_neg_r  <= cmd_data.dir_x_neg;
      dir_y_neg_r  <= cmd_data.dir_y_neg;
      span_x_r     <= cmd_data.span_x;
      neg_span_y_r <= cmd_data.neg_span_y;
      err_r        <= err_init;
      color_r      <= cmd_data.color;
    end else if (res_push && !last) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  `CLR_ASSERT_ALWAYS(a_reset_clears_line, !rst_n |=> !active_r)
  `CLR_ASSERT(a_last_ends_line, (res_push && res_data.last) |=> !active_r)
  `CLR_ASSERT(a_line_holds, (active_r && !cmd_pop) |=> active_r)

endmodule
`default_nettype wire

// ===== rtl/clipped_line_rasterizer_core.sv =====
// Clipped line rasteriser: steps a Bresenham line, one pixel per request.
// Input queue (push/full, in_data): a start request loads both endpoints and
//   the colour and gives no pixel; each step request gives the next pixel.
//   A step request with no line running is dropped.
// Output queue (empty/pop, out_data): oldest pixel shown while empty is low,
//   with visible (strictly inside the window) and last (line finished).
// Config (cfg_valid/cfg_ready, cfg_index, cfg_wdata): window width at index
//   0, height at index 1; always ready, write only while the block is idle.
// Throughput: one request per clock in either direction while full stays low.
// Path: a step request, once taken, passes the front classify register, the
//   command queue and the back step engine into the output queue before its
//   pixel shows.
// Receiver stall: the output queue fills, the back engine halts, the command
//   queue fills and then full rises; nothing is lost.
// Reset: queues empty, no line running, width 1920, height 1080.
`default_nettype none
module clipped_line_rasterizer_core
  import clr_pkg::*;
#(
  parameter int CMDQ_DEPTH = 4,
  parameter int RESQ_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input request queue
  input  wire logic                push,
  input  wire in_item_t            in_data,
  output logic                     full,
  // result queue
  output logic                     empty,
  input  wire logic                pop,
  output out_item_t                out_data,
  // configuration writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [DIM_BITS-1:0] cfg_wdata
);

  // window registers
  logic [DIM_BITS-1:0] width_r, height_r;
  win_cfg_t            win;

  // front to command queue
  logic q_push, q_full;
  cmd_t q_wdata;

  // command queue to back
  logic                q_pop, q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  // back to result queue
  logic      res_push, res_full;
  out_item_t res_data;
  logic [$bits(out_item_t)-1:0] res_rdata;

  assign cfg_ready  = 1'b1;
  assign win.width  = width_r;
  assign win.height = height_r;
  assign out_data   = out_item_t'(res_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: takes requests, works out spans and directions
  clr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (push),
    .in_data (in_data),
    .in_full (full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  // short queue decoupling the front from the step engine
  clr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: Bresenham step engine and window clip
  clr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd_data  (cmd_t'(q_rdata)),
    .cmd_pop   (q_pop),
    .win       (win),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  // result queue; also parts the engine from a stalled receiver
  clr_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

endmodule
`default_nettype wire
